// ===== src/pf_pkg.sv =====
// pf_pkg: shared types, codes and helper functions of the Playfair encrypt block.
// Used by playfair_encrypt. Depends on nothing else.
package pf_pkg;

	// Square geometry
	localparam int GRID_SIDE = 5;
	localparam int CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int LETTER_W  = 5;   // letter index 0..24
	localparam int POS_W     = 5;   // square position 0..24
	localparam int RC_W      = 3;   // row or column 0..4

	// Letter index of X in the alphabet without J, used as pad
	localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd22;
	// Letter index of K, first letter after the J gap
	localparam logic [LETTER_W-1:0] AFTER_J_IDX = 5'd9;

	// ASCII codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_J     = 8'h4A;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;
	localparam logic [6:0] ASC_A    = 7'h41;

	// Action codes of an input beat
	typedef enum logic [1:0] {
		ACT_KEY    = 2'd0,
		ACT_FINISH = 2'd1,
		ACT_PLAIN  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_POSA,
		S_POSB,
		S_CALC,
		S_SQ1,
		S_SQ2,
		S_EMIT1,
		S_EMIT2
	} state_t;

	// Channel beats
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic [6:0] cipher_char;
		logic       pair_end;
		logic       error;
	} out_beat_t;

	typedef struct packed {
		logic                ok;
		logic [LETTER_W-1:0] idx;
	} letter_t;

	typedef struct packed {
		logic [RC_W-1:0] row;
		logic [RC_W-1:0] col;
	} rc_t;

	// Byte to letter index: fold case, fold J to I, skip the J gap
	function automatic letter_t letter_index(logic [7:0] code);
		letter_t    li;
		logic [7:0] c;
		c = code;
		if (c inside {[CH_LA:CH_LZ]})
			c = c - CASE_GAP;
		li.ok = (c inside {[CH_A:CH_Z]});
		if (c == CH_J)
			c = CH_I;
		li.idx = LETTER_W'(c - CH_A - ((c > CH_J) ? 8'd1 : 8'd0));
		return li;
	endfunction

	// Letter index to upper-case ASCII
	function automatic logic [6:0] letter_ascii(logic [LETTER_W-1:0] idx);
		return ASC_A + 7'(idx) + ((idx >= AFTER_J_IDX) ? 7'd1 : 7'd0);
	endfunction

	// Square position to row and column
	function automatic rc_t pos_split(logic [POS_W-1:0] pos);
		rc_t rc;
		rc.row = '0;
		for (int r = 1; r < GRID_SIDE; r++) begin
			if (pos >= POS_W'(r * GRID_SIDE))
				rc.row = RC_W'(r);
		end
		rc.col = RC_W'(pos - POS_W'(rc.row * GRID_SIDE));
		return rc;
	endfunction

	// Row and column to square position
	function automatic logic [POS_W-1:0] pos_join(logic [RC_W-1:0] row, logic [RC_W-1:0] col);
		return POS_W'(row * GRID_SIDE) + POS_W'(col);
	endfunction

	// Step one row or column with wrap-around
	function automatic logic [RC_W-1:0] wrap_inc(logic [RC_W-1:0] v);
		return (v == RC_W'(GRID_SIDE - 1)) ? '0 : v + RC_W'(1);
	endfunction

endpackage

// ===== src/pf_ram.sv =====
// pf_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the key square and the letter position tables.
module pf_ram #(
	parameter int WIDTH  = 5,
	parameter int DEPTH  = 25,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== src/playfair_encrypt.sv =====
// playfair_encrypt: builds a 5x5 Playfair key square and encrypts letter pairs.
// Key byte or held letter: handled on the beat itself; rejected byte: error beat out the next cycle.
// Finish: the beat, then one alphabet letter checked per cycle and placed if not yet used.
// Letter that completes a pair: two reads in turn from each table RAM, then the two results
// out in order, each held while the output stalls; next beat taken once both are out.
// Reset (arst_n, async) clears control state; table RAM contents are not cleared.
module playfair_encrypt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              plain_valid,
	output logic              plain_stall,
	input  pf_pkg::in_beat_t  plain_beat,
	output logic              cipher_valid,
	input  logic              cipher_stall,
	output pf_pkg::out_beat_t cipher_beat
);
	import pf_pkg::*;

	state_t              state_q, state_d;
	logic                square_ready_q;
	logic [CELLS-1:0]    letter_used_q;
	logic [POS_W-1:0]    fill_cnt_q;
	logic [LETTER_W-1:0] fill_idx_q;
	logic [LETTER_W-1:0] held_q;
	logic                holding_q;
	logic                out_valid_q;
	out_beat_t           out_q;

	logic [LETTER_W-1:0] a_q, b_q;
	logic [POS_W-1:0]    pa_q, p1_q, p2_q;
	logic [LETTER_W-1:0] l1_q;

	logic                accept, out_free;
	letter_t             lx;
	logic                place_en;
	logic [LETTER_W-1:0] place_letter;
	logic                go_fill, go_pair, hold_set, err_res;
	logic [LETTER_W-1:0] pair_a, pair_b;
	logic                out_load;
	out_beat_t           out_d;
	logic [LETTER_W-1:0] pos_rd_addr;
	logic [POS_W-1:0]    pos_rdata;
	logic [POS_W-1:0]    sq_rd_addr;
	logic [LETTER_W-1:0] sq_rdata;
	rc_t                 rca, rcb;
	logic [POS_W-1:0]    p1_d, p2_d;

	assign accept   = plain_valid && !plain_stall;
	assign out_free = !out_valid_q || !cipher_stall;
	assign lx       = letter_index(plain_beat.char_code);

	// one beat at a time, taken only when idle with the result slot empty
	assign plain_stall  = (state_q != S_IDLE) || out_valid_q;
	assign cipher_valid = out_valid_q;
	assign cipher_beat  = out_q;

	// table RAMs: letter at each position, position of each letter
	pf_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_sq_ram (
		.clk     (clk),
		.wr_en   (place_en),
		.wr_addr (fill_cnt_q),
		.wr_data (place_letter),
		.rd_addr (sq_rd_addr),
		.rd_data (sq_rdata)
	);

	pf_ram #(.WIDTH(POS_W), .DEPTH(CELLS)) u_pos_ram (
		.clk     (clk),
		.wr_en   (place_en),
		.wr_addr (place_letter),
		.wr_data (fill_cnt_q),
		.rd_addr (pos_rd_addr),
		.rd_data (pos_rdata)
	);

	// pair geometry: same row, same column or rectangle
	always_comb begin
		rca = pos_split(pa_q);
		rcb = pos_split(pos_rdata);
		if (rca.row == rcb.row) begin
			p1_d = pos_join(rca.row, wrap_inc(rca.col));
			p2_d = pos_join(rcb.row, wrap_inc(rcb.col));
		end else if (rca.col == rcb.col) begin
			p1_d = pos_join(wrap_inc(rca.row), rca.col);
			p2_d = pos_join(wrap_inc(rcb.row), rcb.col);
		end else begin
			p1_d = pos_join(rca.row, rcb.col);
			p2_d = pos_join(rcb.row, rca.col);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (go_fill)
					state_d = S_FILL;
				else if (go_pair)
					state_d = S_POSA;
			end
			S_FILL: begin
				if (fill_idx_q == LETTER_W'(CELLS - 1))
					state_d = S_IDLE;
			end
			S_POSA:  state_d = S_POSB;
			S_POSB:  state_d = S_CALC;
			S_CALC:  state_d = S_SQ1;
			S_SQ1:   state_d = S_SQ2;
			S_SQ2:   state_d = S_EMIT1;
			S_EMIT1: if (out_free) state_d = S_EMIT2;
			S_EMIT2: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// beat decode and sequencer outputs
	always_comb begin
		place_en     = 1'b0;
		place_letter = lx.idx;
		go_fill      = 1'b0;
		go_pair      = 1'b0;
		hold_set     = 1'b0;
		err_res      = 1'b0;
		pair_a       = held_q;
		pair_b       = lx.idx;
		out_load     = 1'b0;
		out_d        = '0;
		pos_rd_addr  = (state_q == S_POSA) ? a_q : b_q;
		sq_rd_addr   = (state_q == S_SQ1) ? p1_q : p2_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (plain_beat.action)
						ACT_KEY: begin
							if (square_ready_q)
								err_res = 1'b1;
							else if (plain_beat.char_code == CH_SPACE)
								err_res = 1'b0;
							else if (!lx.ok)
								err_res = 1'b1;
							else
								place_en = !letter_used_q[lx.idx] &&
									(fill_cnt_q < POS_W'(CELLS));
						end
						ACT_FINISH: go_fill = !square_ready_q;
						ACT_PLAIN: begin
							if (!square_ready_q || !lx.ok) begin
								err_res = 1'b1;
							end else if (holding_q) begin
								go_pair = 1'b1;
							end else if (plain_beat.last) begin
								go_pair = 1'b1;
								pair_a  = lx.idx;
								pair_b  = PAD_LETTER;
							end else begin
								hold_set = 1'b1;
							end
						end
						default: ;
					endcase
				end
				if (err_res) begin
					out_load    = 1'b1;
					out_d.error = 1'b1;
				end
			end
			S_FILL: begin
				place_letter = fill_idx_q;
				place_en     = !letter_used_q[fill_idx_q] && (fill_cnt_q < POS_W'(CELLS));
			end
			S_EMIT1: begin
				out_load          = out_free;
				out_d.cipher_char = letter_ascii(l1_q);
			end
			S_EMIT2: begin
				out_load          = out_free;
				out_d.cipher_char = letter_ascii(sq_rdata);
				out_d.pair_end    = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			square_ready_q <= 1'b0;
			letter_used_q  <= '0;
			fill_cnt_q     <= '0;
			fill_idx_q     <= '0;
			held_q         <= '0;
			holding_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (place_en) begin
				letter_used_q[place_letter] <= 1'b1;
				fill_cnt_q                  <= fill_cnt_q + POS_W'(1);
			end
			if (hold_set) begin
				held_q    <= lx.idx;
				holding_q <= 1'b1;
			end else if (go_pair) begin
				holding_q <= 1'b0;
			end
			if (state_q == S_FILL) begin
				if (fill_idx_q == LETTER_W'(CELLS - 1)) begin
					fill_idx_q     <= '0;
					square_ready_q <= 1'b1;
					holding_q      <= 1'b0;
					held_q         <= '0;
				end else begin
					fill_idx_q <= fill_idx_q + LETTER_W'(1);
				end
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!cipher_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (go_pair) begin
			a_q <= pair_a;
			b_q <= pair_b;
		end
		if (state_q == S_POSB)
			pa_q <= pos_rdata;
		if (state_q == S_CALC) begin
			p1_q <= p1_d;
			p2_q <= p2_d;
		end
		if (state_q == S_SQ2)
			l1_q <= sq_rdata;
		if (out_load)
			out_q <= out_d;
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_cnt_q <= POS_W'(CELLS))
		else $error("fill count past square size");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		square_ready_q |=> square_ready_q)
		else $error("square ready dropped");

	a_fill_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL && fill_idx_q == LETTER_W'(CELLS - 1)) |=>
			(&letter_used_q && fill_cnt_q == POS_W'(CELLS)))
		else $error("square not full after finish");

	a_cipher_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.error) |-> square_ready_q)
		else $error("cipher letter before square ready");

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT2) |-> ($past(state_q) == S_EMIT1 || $past(state_q) == S_EMIT2))
		else $error("second pair letter out of order");

endmodule
